/* hdl/ryuv_pkg.sv */
// Shared types and constants for the RGBA to YUV 4:2:0 converter.
`default_nettype none
package ryuv_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [11:0] HALF_W_LIM = 12'(MAX_WIDTH / 2);
    localparam logic [11:0] HALF_H_LIM = 12'(MAX_HEIGHT / 2);

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 104;

    typedef enum logic [1:0] {
        CFG_HALF_WIDTH  = 2'd0,
        CFG_HALF_HEIGHT = 2'd1,
        CFG_SEMI_PLANAR = 2'd2,
        CFG_ALPHA_ONLY  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } t_yuv;

endpackage
`default_nettype wire

/* hdl/ryuv_csc.sv */
// BT.601 limited-range color space conversion of one RGBA pixel.
`default_nettype none
module ryuv_csc (
    input  var ryuv_pkg::t_pix i_pix,
    input  wire                i_alpha_only,
    output var ryuv_pkg::t_yuv o_yuv
);
    import ryuv_pkg::*;

    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] y_sum;
    logic [16:0] u_sum;
    logic [16:0] v_sum;

    always_comb begin
        red   = i_alpha_only ? i_pix.alpha : i_pix.red;
        green = i_alpha_only ? i_pix.alpha : i_pix.green;
        blue  = i_alpha_only ? i_pix.alpha : i_pix.blue;

        y_sum = {8'd0, red} * 16'd66 + {8'd0, green} * 16'd129
              + {8'd0, blue} * 16'd25 + 16'd128;
        // biased sums stay in 0..65535, so the shift is a plain byte select
        u_sum = {9'd0, blue} * 17'd112 + 17'd32896
              - {9'd0, red} * 17'd38 - {9'd0, green} * 17'd74;
        v_sum = {9'd0, red} * 17'd112 + 17'd32896
              - {9'd0, green} * 17'd94 - {9'd0, blue} * 17'd18;

        o_yuv.y = y_sum[15:8] + 8'd16;
        o_yuv.u = u_sum[15:8];
        o_yuv.v = v_sum[15:8];
    end

endmodule
`default_nettype wire

/* hdl/rgba_to_yuv420_converter.sv */
// Top level: RGBA pixel stream in, YUV 4:2:0 bytes with buffer offsets out.
`default_nettype none
// Takes one RGBA pixel per clock in raster order while the output is not stalled
// and no configuration word is presented, and returns one word per pixel through
// an input register and a result register with the color conversion and offset
// adders between them. Sizes are set as half width and half height; a zero size
// acts as one and sizes above half the maximum are held at that bound. A pixel
// offered while a configuration word is presented waits until that word is gone.
// Configure only while the stream is idle.
module rgba_to_yuv420_converter (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  wire  [ryuv_pkg::S_DATA_W-1:0]       i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    // luma_value[7:0], luma_offset[31:8], u_value[39:32], v_value[47:40],
    // u_offset[72:48], v_offset[97:73], zero[103:98]
    output logic [ryuv_pkg::M_DATA_W-1:0]       o_m_tdata,
    // chroma_valid[0]
    output logic                                o_m_tuser,
    output logic                                o_m_tlast,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  var ryuv_pkg::t_cfg_idx              i_cfg_index,
    input  wire  [11:0]                         i_cfg_data
);
    import ryuv_pkg::*;

    logic [11:0] r_half_w;
    logic [11:0] r_half_h;
    logic        r_semi;
    logic        r_alpha_only;
    logic [22:0] r_quarter;

    logic [11:0] r_col;
    logic [11:0] r_row;
    logic [23:0] r_lpos;
    logic [21:0] r_cpos;

    logic        r_s1_vld;
    t_pix        r_s1_pix;
    logic        r_s1_chroma;
    logic        r_s1_last;
    logic [23:0] r_s1_lpos;
    logic [21:0] r_s1_cpos;

    logic        r_out_vld;
    t_yuv        r_out_yuv;
    logic [23:0] r_out_lpos;
    logic        r_out_chroma;
    logic [24:0] r_out_uoff;
    logic [24:0] r_out_voff;
    logic        r_out_last;

    logic [11:0] eff_w;
    logic [11:0] eff_h;
    logic [12:0] width;
    logic [12:0] height;
    logic        s_acc;
    logic        s1_adv;
    logic        row_end;
    logic        n_last;
    logic        n_chroma;
    logic [24:0] ysize;
    logic [24:0] vbase;
    logic [24:0] cpos_ext;
    logic [24:0] n_uoff;
    logic [24:0] n_voff;
    t_yuv        yuv;

    ryuv_csc u_csc (
        .i_pix        (r_s1_pix),
        .i_alpha_only (r_alpha_only),
        .o_yuv        (yuv)
    );

    always_comb begin
        eff_w = (r_half_w == 12'd0) ? 12'd1 : ((r_half_w > HALF_W_LIM) ? HALF_W_LIM : r_half_w);
        eff_h = (r_half_h == 12'd0) ? 12'd1 : ((r_half_h > HALF_H_LIM) ? HALF_H_LIM : r_half_h);
        width  = {eff_w, 1'b0};
        height = {eff_h, 1'b0};

        s1_adv     = !r_out_vld || i_m_tready;
        o_s_tready = (!r_s1_vld || s1_adv) && !i_cfg_valid;
        o_cfg_ready = 1'b1;
        s_acc      = i_s_tvalid && o_s_tready;

        row_end  = ({1'b0, r_col} + 13'd1) >= width;
        n_last   = row_end && (({1'b0, r_row} + 13'd1) >= height);
        n_chroma = !r_row[0] && !r_col[0];

        ysize    = {r_quarter, 2'b00};
        vbase    = ysize + {2'b00, r_quarter};
        cpos_ext = {3'd0, r_s1_cpos};
        if (!r_s1_chroma) begin
            n_uoff = '0;
            n_voff = '0;
        end else if (r_semi) begin
            n_uoff = ysize + {cpos_ext[23:0], 1'b0};
            n_voff = ysize + {cpos_ext[23:0], 1'b1};
        end else begin
            n_uoff = ysize + cpos_ext;
            n_voff = vbase + cpos_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_w     <= 12'd1;
            r_half_h     <= 12'd1;
            r_semi       <= 1'b0;
            r_alpha_only <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HALF_WIDTH:  r_half_w     <= i_cfg_data;
                CFG_HALF_HEIGHT: r_half_h     <= i_cfg_data;
                CFG_SEMI_PLANAR: r_semi       <= i_cfg_data[0];
                CFG_ALPHA_ONLY:  r_alpha_only <= i_cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_quarter <= {11'd0, eff_w} * {11'd0, eff_h};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_lpos <= '0;
            r_cpos <= '0;
        end else if (s_acc) begin
            if (n_last) begin
                r_col  <= '0;
                r_row  <= '0;
                r_lpos <= '0;
                r_cpos <= '0;
            end else begin
                r_lpos <= r_lpos + 24'd1;
                if (n_chroma) begin
                    r_cpos <= r_cpos + 22'd1;
                end
                if (row_end) begin
                    r_col <= '0;
                    r_row <= r_row + 12'd1;
                end else begin
                    r_col <= r_col + 12'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_pix    <= t_pix'(i_s_tdata);
            r_s1_chroma <= n_chroma;
            r_s1_last   <= n_last;
            r_s1_lpos   <= r_lpos;
            r_s1_cpos   <= r_cpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_out_yuv.y  <= yuv.y;
            r_out_yuv.u  <= r_s1_chroma ? yuv.u : 8'd0;
            r_out_yuv.v  <= r_s1_chroma ? yuv.v : 8'd0;
            r_out_lpos   <= r_s1_lpos;
            r_out_chroma <= r_s1_chroma;
            r_out_uoff   <= n_uoff;
            r_out_voff   <= n_voff;
            r_out_last   <= r_s1_last;
        end
    end

    always_comb begin
        o_m_tvalid = r_out_vld;
        o_m_tlast  = r_out_last;
        o_m_tuser  = r_out_chroma;
        o_m_tdata  = {6'd0, r_out_voff, r_out_uoff, r_out_yuv.v, r_out_yuv.u,
                      r_out_lpos, r_out_yuv.y};
    end

`ifndef SYNTH
    a_no_cfg_during_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_acc && i_cfg_valid && o_cfg_ready))
        else $error("pixel accepted together with a configuration word");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && n_last) |=> (r_col == 12'd0 && r_row == 12'd0 &&
                               r_lpos == 24'd0 && r_cpos == 22'd0))
        else $error("position counters not cleared after last pixel");

    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_s1_vld))
        else $error("output word raised without a pixel in the input register");
`endif

endmodule
`default_nettype wire
